// File: src/clni_pkg.sv
// Shared types and constants for the character LCD 4-bit bus sequencer.
// No dependencies; imported by clni_ctrl, clni_dp and char_lcd_nibble_interface.
package clni_pkg;

   // Operation codes carried in the request
   typedef enum logic [1:0] {
      OP_COMMAND = 2'd0,
      OP_DATA    = 2'd1,
      OP_CURSOR  = 2'd2,
      OP_INIT    = 2'd3
   } clni_op_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_COMMAND_WAIT = 2'd0;
   localparam logic [1:0] CSR_DATA_WAIT    = 2'd1;
   localparam logic [1:0] CSR_INIT_WAIT    = 2'd2;

   // Reset values of the wait registers, in microseconds
   localparam logic [15:0] COMMAND_WAIT_RST = 16'd2000;
   localparam logic [15:0] DATA_WAIT_RST    = 16'd37;
   localparam logic [15:0] INIT_WAIT_RST    = 16'd5000;

   // Display command constants
   localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
   localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
   localparam logic [3:0] MODE4_NIBBLE   = 4'h2;
   localparam int unsigned MAX_ROW       = 3;

   // Step counts: a byte takes 4 pin states, init takes 24
   localparam int unsigned STEP_W        = 5;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd23;
   localparam logic [STEP_W-1:0] INIT_NIB_STEPS = 5'd8;  // 4 wake-up nibbles x 2 states
   localparam logic [STEP_W-1:0] INIT_MODE_STEP = 5'd6;  // first state of the 0x2 nibble

   // Init command bytes after the wake-up nibbles
   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h01;  // clear display
         2'd1:    b = 8'h06;  // entry mode, increment
         2'd2:    b = 8'h0C;  // display on, cursor off
         2'd3:    b = 8'h10;  // cursor shift
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Controller state
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } clni_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // latch the request and clear the step counter
      logic emit;   // write current pin state into the output register, step on
   } clni_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;   // output register empty or being drained this cycle
      logic step_last;  // current pin state ends the run
   } clni_stat_type;

endpackage

// File: src/char_lcd_nibble_interface.sv
// Top level of the character LCD 4-bit bus sequencer.
// Depends on clni_pkg, clni_ctrl and clni_dp.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------
//   req_    | in  | req_tvalid/tready    | op, byte_value, column, row
//   rsp_    | out | rsp_tvalid/tready    | pin state, wait, error, last
//   csr_    | in  | csr_valid/ready      | register index, 16-bit value
//
// A request produces one pin state per cycle while the result side takes
// them: 4 for a byte or cursor move, 1 for a bad cursor, 24 for init, set by
// the single step counter walking the run. One request is worked at a time;
// the next is taken the cycle after the last pin state enters the output
// register. Stalls on rsp_tready freeze the step counter. Reset is
// synchronous; the wait registers return to 2000/37/5000 us.
module char_lcd_nibble_interface
   import clni_pkg::*;
#(
   parameter int unsigned LINE_STRIDE = 40  // display line stride, 1 to 64
) (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] byte_value, [13:8] column, [16:14] row
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,   // [1:0] op
   // result: [3:0] nibble, [4] enable, [5] reg_select, [6] read_write,
   //         [22:7] wait_us
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] error
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   clni_cmd_type  cmd;
   clni_stat_type stat;

   // Registers must be written only while idle; this block does not check it, so writes are always taken
   assign csr_ready = 1'b1;

   clni_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   clni_dp #(
      .LINE_STRIDE (LINE_STRIDE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (req_tuser),
      .byte_value (req_tdata[7:0]),
      .column     (req_tdata[13:8]),
      .row        (req_tdata[16:14]),
      .csr_we     (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: src/clni_ctrl.sv
// Run controller for the LCD bus sequencer: takes a request, then steps the
// datapath once per free output slot. Depends on clni_pkg.
module clni_ctrl
   import clni_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  clni_stat_type stat,
   output clni_cmd_type  cmd
);

   clni_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.out_free && stat.step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.emit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_RUN: begin
            cmd.emit = stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

// File: src/clni_dp.sv
// Datapath for the LCD bus sequencer: wait registers, latched request,
// step counter, pin state generation and output register. Depends on clni_pkg.
module clni_dp
   import clni_pkg::*;
#(
   parameter int unsigned LINE_STRIDE = 40
) (
   input  logic          clock,
   input  logic          reset,
   // request payload
   input  logic [1:0]    op,
   input  logic [7:0]    byte_value,
   input  logic [5:0]    column,
   input  logic [2:0]    row,
   // configuration writes
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data,
   // control
   input  clni_cmd_type  cmd,
   output clni_stat_type stat,
   // result
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   localparam logic [6:0] STRIDE_W = 7'(LINE_STRIDE);

   logic [15:0] cmd_wait_ff, dat_wait_ff, ini_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_wait_ff <= COMMAND_WAIT_RST;
         dat_wait_ff <= DATA_WAIT_RST;
         ini_wait_ff <= INIT_WAIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COMMAND_WAIT: cmd_wait_ff <= csr_data;
            CSR_DATA_WAIT:    dat_wait_ff <= csr_data;
            CSR_INIT_WAIT:    ini_wait_ff <= csr_data;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // Cursor address and range check, resolved at load
   logic [8:0] cur_sum;
   logic [7:0] cur_addr;
   logic       cur_bad;

   always_comb begin
      cur_sum  = 9'(row * STRIDE_W) + {3'b000, column};
      cur_addr = SET_DDRAM_ADDR | cur_sum[7:0];
      cur_bad  = ({1'b0, column} >= STRIDE_W) || (32'(row) > MAX_ROW);
   end

   clni_op_type      op_ff;
   logic [7:0]       byte_ff;
   logic             err_ff;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= clni_op_type'(op);
         byte_ff <= (op == OP_CURSOR) ? cur_addr : byte_value;
         err_ff  <= (op == OP_CURSOR) && cur_bad;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.load) begin
         step_in = '0;
      end else if (cmd.emit) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // Pin state for the current step
   logic [STEP_W-1:0] bstep;
   logic [7:0]        cur_byte;
   logic [15:0]       byte_wait;
   logic [3:0]        g_nibble;
   logic              g_enable, g_rs, g_err, g_last;
   logic [15:0]       g_wait;

   always_comb begin
      bstep     = step_ff - INIT_NIB_STEPS;
      cur_byte  = byte_ff;
      byte_wait = (op_ff == OP_DATA) ? dat_wait_ff : cmd_wait_ff;
      g_enable  = ~step_ff[0];
      g_rs      = (op_ff == OP_DATA);
      g_err     = 1'b0;
      g_wait    = '0;
      g_nibble  = '0;
      g_last    = 1'b0;
      if (op_ff == OP_INIT) begin
         if (step_ff < INIT_NIB_STEPS) begin
            // wake-up nibbles 3,3,3 then 2
            g_nibble = (step_ff < INIT_MODE_STEP) ? WAKE_NIBBLE : MODE4_NIBBLE;
            g_wait   = step_ff[0] ? ini_wait_ff : 16'd0;
         end else begin
            cur_byte = init_byte(bstep[3:2]);
            g_nibble = bstep[1] ? cur_byte[3:0] : cur_byte[7:4];
            g_wait   = (bstep[1:0] == 2'd3) ? cmd_wait_ff : 16'd0;
         end
         g_last = (step_ff == INIT_LAST_STEP);
      end else if (err_ff) begin
         g_enable = 1'b0;
         g_rs     = 1'b0;
         g_err    = 1'b1;
         g_last   = 1'b1;
      end else begin
         g_nibble = step_ff[1] ? cur_byte[3:0] : cur_byte[7:4];
         g_wait   = (step_ff == BYTE_LAST_STEP) ? byte_wait : 16'd0;
         g_last   = (step_ff == BYTE_LAST_STEP);
      end
   end

   // Output register
   logic        out_valid_ff;
   logic [23:0] out_data_ff;
   logic        out_err_ff, out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_data_ff <= {1'b0, g_wait, 1'b0, g_rs, g_enable, g_nibble};
         out_err_ff  <= g_err;
         out_last_ff <= g_last;
      end
   end

   assign stat.out_free  = ~out_valid_ff | rsp_tready;
   assign stat.step_last = g_last;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_err_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
